### design/hbrp_pkg.sv
// Shared types and constants for the heap break and region placer.
package hbrp_pkg;

   // Request kinds carried on req_type.
   localparam logic REQ_HEAP   = 1'b0;
   localparam logic REQ_REGION = 1'b1;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEAP_BASE      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEAP_LIMIT_SET = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEAP_LIMIT     = 2'd2;

   // Fixed field widths.
   localparam int unsigned WORD_BITS  = 32;
   localparam int unsigned COLOR_IN_BITS = 2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEAP,
      S_PREP,
      S_SEARCH,
      S_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch the request fields
      logic heap_exec;   // evaluate a heap request and load the response
      logic region_fail; // load a failed response for a zero-size region
      logic prep;        // set up alignment mask, page-rounded size and start slot
      logic step;        // one aligned slot of the color search
      logic finish;      // load the placed address and advance the cursor
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic size_zero;
      logic search_done;
   } status_type;

endpackage

### design/hbrp_ctrl.sv
// Controller state machine for the heap break and region placer.
module hbrp_ctrl
   import hbrp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_type,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      load_out;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_out  = cmd.heap_exec || cmd.region_fail || cmd.finish;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_type == REQ_REGION) ? S_PREP : S_HEAP;
            end
         end
         S_HEAP: begin
            if (out_free) begin
               cmd.heap_exec = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_PREP: begin
            if (status.size_zero) begin
               if (out_free) begin
                  cmd.region_fail = 1'b1;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.prep = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.step = 1'b1;
            if (status.search_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // A response is never loaded over one that is still waiting.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("response loaded while the previous one was stalled");

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_step_stays: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> (state_ff == S_SEARCH || state_ff == S_FINISH))
      else $error("color search left without finishing");

endmodule

### design/hbrp_datapath.sv
// Datapath of the heap break and region placer: registers, adders and color search.
module hbrp_datapath
   import hbrp_pkg::*;
#(
   parameter int unsigned ADDR_WIDTH = 32,
   parameter int unsigned PAGE_BITS  = 12,
   parameter int unsigned COLOR_BITS = 2,
   parameter logic [31:0] MAX_HEAP   = 32'd1073741824
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]      csr_wdata,
   input  logic signed [WORD_BITS-1:0] req_heap_incr,
   input  logic [WORD_BITS-1:0]      req_region_size,
   input  logic [COLOR_IN_BITS-1:0]  req_page_color,
   input  logic                      req_resize_granted,
   input  cmd_type                   cmd,
   output status_type                status,
   output logic                      rsp_ok,
   output logic [WORD_BITS-1:0]      rsp_address
);

   localparam int unsigned TRY_BITS   = COLOR_BITS + 1;
   localparam int unsigned CMP_BITS   = (COLOR_BITS > COLOR_IN_BITS) ? COLOR_BITS : COLOR_IN_BITS;
   localparam int unsigned LARGE_BIT  = COLOR_BITS + PAGE_BITS - 1;
   localparam logic [TRY_BITS-1:0]   LAST_TRY   = TRY_BITS'((32'd1 << COLOR_BITS) - 32'd1);
   localparam logic [ADDR_WIDTH-1:0] PAGE_MASK  = ADDR_WIDTH'((32'd1 << PAGE_BITS) - 32'd1);
   localparam logic [ADDR_WIDTH-1:0] COLOR_MASK = ADDR_WIDTH'((32'd1 << COLOR_BITS) - 32'd1);
   localparam logic [32:0] SIZE_MAX = (ADDR_WIDTH >= 32) ? 33'h0_FFFF_FFFF :
                                      33'((64'd1 << ADDR_WIDTH) - 64'd1);

   // Configuration and architectural state.
   logic [WORD_BITS-1:0]  heap_base_ff, heap_limit_ff;
   logic                  heap_limit_set_ff;
   logic [WORD_BITS-1:0]  heap_used_ff, heap_used_in;
   logic [ADDR_WIDTH-1:0] cursor_ff, cursor_in;
   logic                  placed_ff, placed_in;
   logic                  dflt_ff, dflt_in;

   // Captured request.
   logic signed [WORD_BITS-1:0] incr_ff;
   logic [WORD_BITS-1:0]        size_ff;
   logic [COLOR_IN_BITS-1:0]    color_ff;
   logic                        granted_ff;

   // Region work registers.
   logic [ADDR_WIDTH-1:0] amask_ff, amask_in;
   logic [ADDR_WIDTH-1:0] psz_ff, psz_in;
   logic [ADDR_WIDTH-1:0] work_ff, work_in;
   logic                  large_ff, large_in;
   logic [TRY_BITS-1:0]   try_ff, try_in;

   // Response registers.
   logic                 rsp_ok_ff, rsp_ok_in;
   logic [WORD_BITS-1:0] rsp_addr_ff, rsp_addr_in;

   // Heap arithmetic.
   logic [33:0]           new_size;
   logic [WORD_BITS-1:0]  limit_value;
   logic                  limit_active;
   logic                  heap_fail;
   logic [ADDR_WIDTH-1:0] heap_addr;
   logic [ADDR_WIDTH+WORD_BITS-1:0] heap_addr_wide;

   // Region arithmetic.
   logic [WORD_BITS-1:0]  smear;
   logic [ADDR_WIDTH-1:0] start_slot;
   logic [ADDR_WIDTH-1:0] cand;
   logic [ADDR_WIDTH-1:0] cand_shift;
   logic [CMP_BITS-1:0]   cand_color;
   logic                  color_match;
   logic [ADDR_WIDTH+WORD_BITS-1:0] work_wide;

   // ---------------- heap request ----------------
   assign limit_value  = heap_limit_set_ff ? heap_limit_ff : MAX_HEAP;
   assign limit_active = heap_limit_set_ff || dflt_ff;
   assign new_size     = {2'b00, heap_used_ff} + {{2{incr_ff[WORD_BITS-1]}}, incr_ff};
   assign heap_fail    = new_size[33] || (new_size[32:0] > SIZE_MAX) ||
                         (limit_active && (new_size[32:0] > {1'b0, limit_value})) ||
                         !granted_ff;
   assign heap_addr      = ADDR_WIDTH'(heap_base_ff) + ADDR_WIDTH'(heap_used_ff);
   assign heap_addr_wide = {{WORD_BITS{1'b0}}, heap_addr};

   // ---------------- region request ----------------
   // Smearing size-1 rightward gives the power-of-two size minus one, at least one.
   always_comb begin
      smear = size_ff - 32'd1;
      smear = smear | (smear >> 1);
      smear = smear | (smear >> 2);
      smear = smear | (smear >> 4);
      smear = smear | (smear >> 8);
      smear = smear | (smear >> 16);
      smear = smear | 32'd1;
   end

   assign start_slot = placed_ff ? cursor_ff :
                       (ADDR_WIDTH'(heap_base_ff) + ADDR_WIDTH'(limit_value));

   // Later tries step one byte past the previous slot before aligning.
   assign cand        = (work_ff + amask_ff + ADDR_WIDTH'(try_ff != '0)) & ~amask_ff;
   assign cand_shift  = (cand >> PAGE_BITS) & COLOR_MASK;
   assign cand_color  = CMP_BITS'(cand_shift);
   assign color_match = (cand_color == CMP_BITS'(color_ff));

   assign status.size_zero   = (size_ff == '0);
   assign status.search_done = large_ff || color_match || (try_ff == LAST_TRY);

   assign work_wide = {{WORD_BITS{1'b0}}, work_ff};

   always_comb begin
      amask_in = amask_ff;
      psz_in   = psz_ff;
      large_in = large_ff;
      work_in  = work_ff;
      try_in   = try_ff;
      if (cmd.prep) begin
         amask_in = ADDR_WIDTH'(smear);
         large_in = smear[LARGE_BIT];
         psz_in   = (ADDR_WIDTH'(size_ff) + PAGE_MASK) & ~PAGE_MASK;
         work_in  = start_slot;
         try_in   = '0;
      end else if (cmd.step) begin
         work_in = cand;
         try_in  = try_ff + TRY_BITS'(1);
      end
   end

   // ---------------- state and response updates ----------------
   always_comb begin
      heap_used_in = heap_used_ff;
      cursor_in    = cursor_ff;
      placed_in    = placed_ff;
      dflt_in      = dflt_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_addr_in  = rsp_addr_ff;
      if (cmd.heap_exec) begin
         rsp_ok_in   = !heap_fail;
         rsp_addr_in = heap_fail ? '0 : heap_addr_wide[WORD_BITS-1:0];
         if (!heap_fail) begin
            heap_used_in = new_size[WORD_BITS-1:0];
         end
      end else if (cmd.region_fail) begin
         rsp_ok_in   = 1'b0;
         rsp_addr_in = '0;
      end else if (cmd.finish) begin
         rsp_ok_in   = 1'b1;
         rsp_addr_in = work_wide[WORD_BITS-1:0];
         cursor_in   = work_ff + psz_ff;
         placed_in   = 1'b1;
         dflt_in     = dflt_ff || !heap_limit_set_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff      <= '0;
         heap_limit_set_ff <= 1'b0;
         heap_limit_ff     <= '0;
         heap_used_ff      <= '0;
         cursor_ff         <= '0;
         placed_ff         <= 1'b0;
         dflt_ff           <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_HEAP_BASE:      heap_base_ff      <= csr_wdata;
               CSR_HEAP_LIMIT_SET: heap_limit_set_ff <= csr_wdata[0];
               CSR_HEAP_LIMIT:     heap_limit_ff     <= csr_wdata;
               default: ;
            endcase
         end
         heap_used_ff <= heap_used_in;
         cursor_ff    <= cursor_in;
         placed_ff    <= placed_in;
         dflt_ff      <= dflt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         incr_ff    <= req_heap_incr;
         size_ff    <= req_region_size;
         color_ff   <= req_page_color;
         granted_ff <= req_resize_granted;
      end
      amask_ff    <= amask_in;
      psz_ff      <= psz_in;
      large_ff    <= large_in;
      work_ff     <= work_in;
      try_ff      <= try_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_addr_ff <= rsp_addr_in;
   end

   assign rsp_ok      = rsp_ok_ff;
   assign rsp_address = rsp_addr_ff;

   a_used_in_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, heap_used_ff} <= SIZE_MAX)
      else $error("heap break beyond the size range");

   a_finish_places: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> placed_ff)
      else $error("cursor not marked placed after a region");

   a_large_no_search: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && large_ff) |-> status.search_done)
      else $error("color search ran for a large region");

endmodule

### design/heap_break_and_region_placer_top.sv
// Top level of the heap break and region placer.
//
// Requests arrive on req_* with valid/ready. req_type 0 moves the heap break by
// req_heap_incr and returns the old end of the heap; req_type 1 places a region
// of req_region_size bytes on the wanted page color and returns its start.
// Each request gives exactly one response on rsp_* (rsp_ok, rsp_address).
// Configuration registers are written through csr_* (index 0 heap base,
// 1 limit enable, 2 heap limit); csr_ready is always high, and writes belong
// in idle periods only.
// A heap request is worked in state S_HEAP. A region request passes through
// S_PREP, then 1 to 2^COLOR_BITS slot tries of the color search unit in
// S_SEARCH, one slot a cycle, then S_FINISH; a zero size fails in S_PREP.
// One request is in work at a time; the next is accepted the cycle after the
// previous response is loaded. The response register holds a result while
// the receiver stalls, so the next request may be taken and worked on
// meanwhile; its result waits until the register is free.
// Reset clears the configuration, the heap break and the region cursor.
module heap_break_and_region_placer_top
   import hbrp_pkg::*;
#(
   parameter int unsigned ADDR_WIDTH = 32,
   parameter int unsigned PAGE_BITS  = 12,
   parameter int unsigned COLOR_BITS = 2,
   parameter logic [31:0] MAX_HEAP   = 32'd1073741824
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_type,
   input  logic signed [WORD_BITS-1:0] req_heap_incr,
   input  logic [WORD_BITS-1:0]        req_region_size,
   input  logic [COLOR_IN_BITS-1:0]    req_page_color,
   input  logic                        req_resize_granted,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_ok,
   output logic [WORD_BITS-1:0]        rsp_address,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [WORD_BITS-1:0]        csr_wdata
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   hbrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hbrp_datapath #(
      .ADDR_WIDTH (ADDR_WIDTH),
      .PAGE_BITS  (PAGE_BITS),
      .COLOR_BITS (COLOR_BITS),
      .MAX_HEAP   (MAX_HEAP)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_heap_incr      (req_heap_incr),
      .req_region_size    (req_region_size),
      .req_page_color     (req_page_color),
      .req_resize_granted (req_resize_granted),
      .cmd                (cmd),
      .status             (status),
      .rsp_ok             (rsp_ok),
      .rsp_address        (rsp_address)
   );

endmodule
